// ===== design/mqpq_pkg.sv =====
// Package with the shared types, widths and codes of the priority queue block.
package mqpq_pkg;
  localparam int unsigned NQ = 4;
  localparam int unsigned DEPTH = 16;
  localparam int unsigned QW = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned IDW = 16;
  localparam int unsigned AGEW = 12;
  localparam int unsigned QNW = 4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BADQ = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_REMOVE,
    KIND_BADQ
  } kind_e;

  typedef struct packed {
    logic [IDW-1:0] id;
    logic [AGEW-1:0] age;
  } entry_t;

  typedef struct packed {
    kind_e kind;
    logic [QW-1:0] qidx;
    entry_t entry;
  } cmd_t;
endpackage

// ===== design/mqpq_if.sv =====
// Handshake interfaces for the input and result channels.
interface mqpq_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [3:0] queue_number;
  logic [15:0] client_id;
  logic [11:0] age;
  modport source (output valid, op, queue_number, client_id, age, input ready);
  modport sink (input valid, op, queue_number, client_id, age, output ready);
endinterface

interface mqpq_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [15:0] served_id;
  logic [11:0] served_age;
  modport source (output valid, status, served_id, served_age, input ready);
  modport sink (input valid, status, served_id, served_age, output ready);
endinterface

// ===== design/mqpq_front.sv =====
// Front part: accepts input beats and classifies them into commands.
module mqpq_front import mqpq_pkg::*; (
  mqpq_in_if.sink in_i,
  input logic cmd_ready_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o
);
  logic bad_q;

  assign bad_q = ({1'b0, in_i.queue_number} >= (QNW + 1)'(NQ));
  assign in_i.ready = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;

  always_comb begin
    cmd_o.qidx = in_i.queue_number[QW-1:0];
    cmd_o.entry.id = in_i.client_id;
    cmd_o.entry.age = in_i.age;
    if (bad_q) begin
      cmd_o.kind = KIND_BADQ;
    end else if (in_i.op == OP_REMOVE) begin
      cmd_o.kind = KIND_REMOVE;
    end else begin
      cmd_o.kind = KIND_INSERT;
    end
  end
endmodule

// ===== design/mqpq_cmd_fifo.sv =====
// Two-entry command queue between the front and back parts.
module mqpq_cmd_fifo import mqpq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic wr_valid_i,
  output logic wr_ready_o,
  input cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input logic rd_ready_i,
  output cmd_t rd_cmd_o
);
  cmd_t mem_q [2];
  logic wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_cmd_o = mem_q[rptr_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign wptr_d = wr ? ~wptr_q : wptr_q;
  assign rptr_d = rd ? ~rptr_q : rptr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_cmd_i;
    end
  end
endmodule

// ===== design/mqpq_back.sv =====
// Back part: sorted cell chains per queue, fill counters and the result register.
module mqpq_back import mqpq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic cmd_valid_i,
  output logic cmd_ready_o,
  input cmd_t cmd_i,
  mqpq_out_if.source out_o
);
  entry_t cells_q [NQ][DEPTH];
  entry_t cells_d [NQ][DEPTH];
  logic [FW-1:0] fill_q [NQ];
  logic [FW-1:0] fill_d [NQ];
  logic keep [NQ][DEPTH];
  logic take;
  logic valid_q, valid_d;
  logic [1:0] status_q, status_d;
  entry_t served_q, served_d;
  logic [FW-1:0] sel_fill;
  entry_t sel_head;

  assign take = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = !valid_q || out_o.ready;
  assign sel_fill = fill_q[cmd_i.qidx];
  assign sel_head = cells_q[cmd_i.qidx][0];

  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      fill_d[q] = fill_q[q];
      for (int i = 0; i < DEPTH; i++) begin
        if (i == 0) begin
          keep[q][i] = (FW'(i) < fill_q[q]) && (cells_q[q][i].age >= cmd_i.entry.age);
        end else begin
          keep[q][i] = (FW'(i) < fill_q[q]) && (cells_q[q][i].age > cmd_i.entry.age);
        end
        cells_d[q][i] = cells_q[q][i];
        if (take && cmd_i.qidx == QW'(q)) begin
          if (cmd_i.kind == KIND_INSERT && fill_q[q] != FW'(DEPTH)) begin
            if (!keep[q][i]) begin
              if (i > 0 && !keep[q][(i > 0) ? i - 1 : 0]) begin
                cells_d[q][i] = cells_q[q][(i > 0) ? i - 1 : 0];
              end else begin
                cells_d[q][i] = cmd_i.entry;
              end
            end
          end else if (cmd_i.kind == KIND_REMOVE && i < DEPTH - 1) begin
            cells_d[q][i] = cells_q[q][(i < DEPTH - 1) ? i + 1 : i];
          end
        end
      end
      if (take && cmd_i.qidx == QW'(q)) begin
        if (cmd_i.kind == KIND_INSERT && fill_q[q] != FW'(DEPTH)) begin
          fill_d[q] = fill_q[q] + FW'(1);
        end else if (cmd_i.kind == KIND_REMOVE && fill_q[q] != '0) begin
          fill_d[q] = fill_q[q] - FW'(1);
        end
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    status_d = status_q;
    served_d = served_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      served_d = '0;
      case (cmd_i.kind)
        KIND_INSERT: status_d = (sel_fill == FW'(DEPTH)) ? ST_FULL : ST_OK;
        KIND_REMOVE: begin
          if (sel_fill == '0) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_OK;
            served_d = sel_head;
          end
        end
        default: status_d = ST_BADQ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int q = 0; q < NQ; q++) begin
        fill_q[q] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    served_q <= served_d;
    cells_q <= cells_d;
  end

  assign out_o.valid = valid_q;
  assign out_o.status = status_q;
  assign out_o.served_id = served_q.id;
  assign out_o.served_age = served_q.age;
endmodule

// ===== design/multi_queue_priority_insert_remove.sv =====
// Top level: several sorted priority queues with insert and remove of the head.
// An accepted input beat passes the command queue, then the back part, to its result beat.
// Throughput: one beat per cycle when the result side takes every beat.
// The back part updates every cell of the selected queue in one step per beat.
// Reset clears the fill counters, the command queue and the result valid bit; cells are unset.
module multi_queue_priority_insert_remove import mqpq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  mqpq_in_if.sink in_i,
  mqpq_out_if.source out_o
);
  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  mqpq_front u_front (
    .in_i(in_i),
    .cmd_ready_i(f_ready),
    .cmd_valid_o(f_valid),
    .cmd_o(f_cmd)
  );

  mqpq_cmd_fifo u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_cmd_i(f_cmd),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_cmd_o(b_cmd)
  );

  mqpq_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_valid_i(b_valid),
    .cmd_ready_o(b_ready),
    .cmd_i(b_cmd),
    .out_o(out_o)
  );
endmodule

// ===== design/mqpq_checker.sv =====
// Port-level checker for the priority queue block and its bind.
module mqpq_port_checker import mqpq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [15:0] out_id,
  input logic [11:0] out_age
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id))
    else $error("stalled result beat changed");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != ST_OK |-> out_id == '0 && out_age == '0)
    else $error("failed beat carries served data");

  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result beat right after reset");
endmodule

bind multi_queue_priority_insert_remove mqpq_port_checker u_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_status(out_o.status),
  .out_id(out_o.served_id),
  .out_age(out_o.served_age)
);
